[hdl/pfbb_pkg.sv]
package pfbb_pkg;

    localparam int ACT_W      = 3;
    localparam int SIZE_W     = 24;
    localparam int HANDLE_W   = 32;
    localparam int COUNT_W    = 9;
    localparam int PLIM_W     = 9;
    localparam int BYTE_W     = 32;
    localparam int SERIAL_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [PLIM_W-1:0] PLIM_RESET = 9'd256;
    localparam logic [BYTE_W-1:0] BLIM_RESET = 32'd16777216;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUT   = 3'd0,
        ACT_GET   = 3'd1,
        ACT_FLUSH = 3'd2,
        ACT_CLOSE = 3'd3,
        ACT_START = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_CLOSED = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PACKET_LIMIT = 2'd0,
        REG_BYTE_LIMIT   = 2'd1
    } reg_index_t;

    typedef enum logic {
        CS_IDLE,
        CS_FETCH
    } ctl_state_t;

    typedef struct packed {
        logic                marker;
        logic                packet;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic                is_flush_marker;
        logic                has_packet;
        logic [SIZE_W-1:0]   packet_size;
        logic [HANDLE_W-1:0] packet_handle;
    } item_t;

    typedef struct packed {
        status_t             status;
        entry_t              entry;
        logic [SERIAL_W-1:0] serial;
        logic [COUNT_W-1:0]  entry_count;
        logic [BYTE_W-1:0]   byte_total;
    } result_t;

    typedef struct packed {
        logic exec;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic get_hit;
    } dp_stat_t;

endpackage

[hdl/pfbb_cmd_if.sv]
interface pfbb_cmd_if;
    import pfbb_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic                is_flush_marker;
    logic                has_packet;
    logic [SIZE_W-1:0]   packet_size;
    logic [HANDLE_W-1:0] packet_handle;

    modport source (
        output valid, action, is_flush_marker, has_packet, packet_size, packet_handle,
        input  ready
    );

    modport sink (
        input  valid, action, is_flush_marker, has_packet, packet_size, packet_handle,
        output ready
    );

endinterface

[hdl/pfbb_rsp_if.sv]
interface pfbb_rsp_if;
    import pfbb_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic                out_is_flush_marker;
    logic                out_has_packet;
    logic [SIZE_W-1:0]   out_size;
    logic [HANDLE_W-1:0] out_handle;
    logic [SERIAL_W-1:0] serial;
    logic [COUNT_W-1:0]  entry_count;
    logic [BYTE_W-1:0]   byte_total;

    modport source (
        output valid, status, out_is_flush_marker, out_has_packet, out_size, out_handle,
               serial, entry_count, byte_total,
        input  ready
    );

    modport sink (
        input  valid, status, out_is_flush_marker, out_has_packet, out_size, out_handle,
               serial, entry_count, byte_total,
        output ready
    );

endinterface

[hdl/pfbb_cfg_if.sv]
interface pfbb_cfg_if;
    import pfbb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

[hdl/pfbb_ctrl.sv]
module pfbb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output pfbb_pkg::ctl_cmd_t  cmd,
    input  pfbb_pkg::dp_stat_t  stat
);
    import pfbb_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        load       = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                cmd.exec = in_valid && in_ready;
                if (cmd.exec)
                begin
                    if (stat.get_hit)
                        state_next = CS_FETCH;
                    else
                        load = 1'b1;
                end
            end
            CS_FETCH:
            begin
                cmd.finish = 1'b1;
                load       = 1'b1;
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase

        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

[hdl/pfbb_dp.sv]
module pfbb_dp #(
    parameter int DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pfbb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfbb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  pfbb_pkg::item_t                     item,
    input  pfbb_pkg::ctl_cmd_t                  cmd,
    output pfbb_pkg::dp_stat_t                  stat,
    output pfbb_pkg::result_t                   result
);
    import pfbb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > PLIM_W) ? CW : PLIM_W;

    entry_t              mem [DEPTH];
    entry_t              rd_reg;
    entry_t              wr_entry;

    logic [AW-1:0]       head_reg, head_next, head_adv;
    logic [AW-1:0]       tail_reg, tail_next, tail_adv;
    logic [CW-1:0]       held_reg, held_next;
    logic [BYTE_W-1:0]   bytes_reg, bytes_next;
    logic                closed_reg, closed_next;
    logic [SERIAL_W-1:0] gen_reg, gen_next;
    logic [PLIM_W-1:0]   plim_reg;
    logic [BYTE_W-1:0]   blim_reg;

    action_t             act;
    logic                counted;
    logic                phys_full;
    logic                cnt_full;
    logic                byte_full;
    logic [BYTE_W:0]     byte_sum;
    status_t             put_status;
    status_t             exec_status;
    logic                mem_we;
    logic                rd_counted;
    logic                load;
    result_t             result_reg;
    result_t             result_next;

    assign act        = action_t'(item.action);
    assign counted    = !item.is_flush_marker && item.has_packet;
    assign phys_full  = (held_reg == CW'(DEPTH));
    assign cnt_full   = (LW'(held_reg) >= LW'(plim_reg));
    assign byte_sum   = {1'b0, bytes_reg} + (BYTE_W + 1)'(item.packet_size);
    assign byte_full  = (byte_sum >= {1'b0, blim_reg});
    assign head_adv   = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign tail_adv   = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
    assign rd_counted = !rd_reg.marker && rd_reg.packet;

    assign stat.get_hit = (act == ACT_GET) && (held_reg != '0);

    always_comb
    begin
        if (counted && closed_reg)
            put_status = ST_CLOSED;
        else if (counted && (cnt_full || byte_full))
            put_status = ST_FULL;
        else if (phys_full)
            put_status = ST_FULL;
        else
            put_status = ST_OK;
    end

    always_comb
    begin
        wr_entry.marker = item.is_flush_marker;
        wr_entry.packet = item.has_packet;
        wr_entry.size   = item.has_packet ? item.packet_size : '0;
        wr_entry.handle = item.has_packet ? item.packet_handle : '0;
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        held_next   = held_reg;
        bytes_next  = bytes_reg;
        closed_next = closed_reg;
        gen_next    = gen_reg;
        exec_status = ST_OK;
        mem_we      = 1'b0;

        if (cmd.exec)
        begin
            unique case (act)
                ACT_PUT:
                begin
                    exec_status = put_status;
                    if (put_status == ST_OK)
                    begin
                        mem_we    = 1'b1;
                        tail_next = tail_adv;
                        held_next = held_reg + CW'(1);
                        if (counted)
                            bytes_next = byte_sum[BYTE_W-1:0];
                    end
                end
                ACT_GET:
                begin
                    if (held_reg != '0)
                    begin
                        head_next = head_adv;
                        held_next = held_reg - CW'(1);
                    end
                    else
                        exec_status = closed_reg ? ST_CLOSED : ST_EMPTY;
                end
                ACT_FLUSH:
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    held_next  = '0;
                    bytes_next = '0;
                    gen_next   = gen_reg + SERIAL_W'(1);
                end
                ACT_CLOSE:
                begin
                    closed_next = 1'b1;
                end
                ACT_START:
                begin
                    closed_next = 1'b0;
                    gen_next    = gen_reg + SERIAL_W'(1);
                end
                default:
                begin
                end
            endcase
        end

        // head entry's bytes come off once the read data is back
        if (cmd.finish && rd_counted)
            bytes_next = bytes_reg - BYTE_W'(rd_reg.size);
    end

    always_comb
    begin
        result_next.status      = cmd.finish ? ST_OK : exec_status;
        result_next.entry       = cmd.finish ? rd_reg : '0;
        result_next.serial      = gen_next;
        result_next.entry_count = COUNT_W'(held_next);
        result_next.byte_total  = bytes_next;
    end

    assign load = (cmd.exec && !stat.get_hit) || cmd.finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            held_reg   <= '0;
            bytes_reg  <= '0;
            closed_reg <= 1'b0;
            gen_reg    <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            held_reg   <= held_next;
            bytes_reg  <= bytes_next;
            closed_reg <= closed_next;
            gen_reg    <= gen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plim_reg <= PLIM_RESET;
            blim_reg <= BLIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_PACKET_LIMIT: plim_reg <= cfg_data[PLIM_W-1:0];
                REG_BYTE_LIMIT:   blim_reg <= cfg_data[BYTE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[tail_reg] <= wr_entry;
        if (cmd.exec)
            rd_reg <= mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

[hdl/packet_fifo_byte_budget.sv]
// Packet descriptor FIFO with an entry limit and a byte budget. One beat on cmd gives exactly
// one beat on rsp, and the block works on one beat at a time: put, flush, close, start and a
// get on an empty queue answer in the cycle after acceptance; a get that pops an entry
// answers after the registered read of the descriptor memory. A new beat is taken once the
// previous response is taken (or in the same cycle): one beat per cycle for non-popping
// operations while rsp is ready. The memory needs no clearing after reset. Registers are
// written over cfg, always ready (index 0 packet limit, index 1 byte limit, other indexes
// ignored). Write them only while no beat is in flight; the block does not enforce it.
module packet_fifo_byte_budget #(
    parameter int DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    pfbb_cmd_if.sink   cmd,
    pfbb_rsp_if.source rsp,
    pfbb_cfg_if.sink   cfg
);
    import pfbb_pkg::*;

    item_t    item;
    result_t  result;
    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    assign item.action          = cmd.action;
    assign item.is_flush_marker = cmd.is_flush_marker;
    assign item.has_packet      = cmd.has_packet;
    assign item.packet_size     = cmd.packet_size;
    assign item.packet_handle   = cmd.packet_handle;

    assign cfg.ready = 1'b1;

    pfbb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (ctl_cmd),
        .stat      (dp_stat)
    );

    pfbb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .item      (item),
        .cmd       (ctl_cmd),
        .stat      (dp_stat),
        .result    (result)
    );

    assign rsp.status              = result.status;
    assign rsp.out_is_flush_marker = result.entry.marker;
    assign rsp.out_has_packet      = result.entry.packet;
    assign rsp.out_size            = result.entry.size;
    assign rsp.out_handle          = result.entry.handle;
    assign rsp.serial              = result.serial;
    assign rsp.entry_count         = result.entry_count;
    assign rsp.byte_total          = result.byte_total;

endmodule

[hdl/pfbb_checker.sv]
module pfbb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [1:0]                    rsp_status,
    input logic                          rsp_marker,
    input logic                          rsp_packet,
    input logic [pfbb_pkg::SIZE_W-1:0]   rsp_size,
    input logic [pfbb_pkg::HANDLE_W-1:0] rsp_handle,
    input logic [pfbb_pkg::SERIAL_W-1:0] rsp_serial,
    input logic [pfbb_pkg::COUNT_W-1:0]  rsp_count,
    input logic [pfbb_pkg::BYTE_W-1:0]   rsp_bytes
);
    import pfbb_pkg::*;

    // every accepted beat is answered next cycle or holds off the next beat
    a_beat_answered: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> rsp_valid || !cmd_ready)
        else $error("accepted beat neither answered nor blocking");

    a_fail_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |->
            !rsp_marker && !rsp_packet && rsp_size == '0 && rsp_handle == '0)
        else $error("refused beat carries entry data");

    a_empty_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0 && rsp_bytes == '0)
        else $error("empty status with entries or bytes held");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_serial)
            && $stable(rsp_count) && $stable(rsp_bytes))
        else $error("stalled response changed");

endmodule

bind packet_fifo_byte_budget pfbb_checker u_pfbb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_marker (rsp.out_is_flush_marker),
    .rsp_packet (rsp.out_has_packet),
    .rsp_size   (rsp.out_size),
    .rsp_handle (rsp.out_handle),
    .rsp_serial (rsp.serial),
    .rsp_count  (rsp.entry_count),
    .rsp_bytes  (rsp.byte_total)
);
